FILE: src/dda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dda_pkg;

  localparam int COORD_BITS   = 9;
  localparam int FRAC_BITS    = 16;
  localparam int POS_BITS     = COORD_BITS + FRAC_BITS;
  localparam int INC_BITS     = FRAC_BITS + 2;
  localparam int QUO_BITS     = FRAC_BITS + 1;
  localparam int DIV_CNT_BITS = $clog2(FRAC_BITS + 1);
  localparam int CQ_DEPTH     = 4;
  localparam int CQ_AW        = 2;
  localparam int RQ_DEPTH     = 2;
  localparam int RQ_AW        = 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [POS_BITS-1:0]   pos_t;
  typedef logic [INC_BITS-1:0]   inc_t;
  typedef logic [QUO_BITS-1:0]   quo_t;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  typedef enum logic {
    ST_RUN = 1'b0,
    ST_DIV = 1'b1
  } state_t;

  // Command as classified by the front end.
  typedef struct packed {
    action_t action;
    coord_t  sx;
    coord_t  sy;
    coord_t  mag_x;
    coord_t  mag_y;
    coord_t  k;
    logic    neg_x;
    logic    neg_y;
  } cmd_t;

  typedef struct packed {
    coord_t px;
    coord_t py;
    logic   last;
    logic   nal;
  } res_t;

  typedef struct packed {
    logic   start;
    coord_t mag_x;
    coord_t mag_y;
    coord_t k;
  } div_req_t;

  typedef struct packed {
    logic done;
    quo_t q_x;
    quo_t q_y;
  } div_rsp_t;

  // Round a position to the nearest pixel, ties upward.
  function automatic coord_t round_pixel(input pos_t pos);
    logic [POS_BITS:0] sum;
    sum = {1'b0, pos} + ((POS_BITS + 1)'(1) << (FRAC_BITS - 1));
    return sum[FRAC_BITS +: COORD_BITS];
  endfunction

endpackage

`default_nettype wire

FILE: src/dda_line_rasterizer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake          Payload
// input     push / full        action, start_x, start_y, end_x, end_y
// result    empty / pop        pixel_x, pixel_y, last_pixel, no_active_line
//
// Step items complete at one per cycle once in the back end while the
// result queue has room. A start item returns its pixel at once but,
// for a line of nonzero length, holds the back end while the shared
// divider forms both increments. A four-entry command queue and a
// two-entry result queue let the input and output sides stall
// independently. Reset (rst, synchronous) empties both queues and ends any line in progress.

module dda_line_rasterizer_top (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 full,
  input  wire logic            action,
  input  wire dda_pkg::coord_t start_x,
  input  wire dda_pkg::coord_t start_y,
  input  wire dda_pkg::coord_t end_x,
  input  wire dda_pkg::coord_t end_y,
  output logic                 empty,
  input  wire logic            pop,
  output dda_pkg::coord_t      pixel_x,
  output dda_pkg::coord_t      pixel_y,
  output logic                 last_pixel,
  output logic                 no_active_line
);

  logic              cmd_valid;
  logic              cmd_take;
  dda_pkg::cmd_t     cmd;
  dda_pkg::div_req_t div_req;
  dda_pkg::div_rsp_t div_rsp;
  dda_pkg::res_t     res;

  dda_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .action    (action),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  dda_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  dda_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign pixel_x        = res.px;
  assign pixel_y        = res.py;
  assign last_pixel     = res.last;
  assign no_active_line = res.nal;

endmodule

`default_nettype wire

FILE: src/dda_front.sv
`timescale 1ns / 1ps
`default_nettype none

module dda_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 full,
  input  wire logic            action,
  input  wire dda_pkg::coord_t start_x,
  input  wire dda_pkg::coord_t start_y,
  input  wire dda_pkg::coord_t end_x,
  input  wire dda_pkg::coord_t end_y,
  output logic                 cmd_valid,
  output dda_pkg::cmd_t        cmd,
  input  wire logic            cmd_take
);

  dda_pkg::cmd_t            mem [dda_pkg::CQ_DEPTH];
  logic [dda_pkg::CQ_AW-1:0] wr_ptr;
  logic [dda_pkg::CQ_AW-1:0] rd_ptr;
  logic [dda_pkg::CQ_AW:0]   count;
  dda_pkg::cmd_t            new_cmd;
  logic                     do_push;
  logic                     do_pop;

  // Classify the item on its way in: deltas, signs and the step count.
  always_comb begin
    new_cmd        = '0;
    new_cmd.action = dda_pkg::action_t'(action);
    new_cmd.sx     = start_x;
    new_cmd.sy     = start_y;
    new_cmd.neg_x  = end_x < start_x;
    new_cmd.neg_y  = end_y < start_y;
    new_cmd.mag_x  = new_cmd.neg_x ? (start_x - end_x) : (end_x - start_x);
    new_cmd.mag_y  = new_cmd.neg_y ? (start_y - end_y) : (end_y - start_y);
    new_cmd.k      = (new_cmd.mag_x > new_cmd.mag_y) ? new_cmd.mag_x : new_cmd.mag_y;
  end

  assign full      = (count == (dda_pkg::CQ_AW + 1)'(dda_pkg::CQ_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/dda_div.sv
`timescale 1ns / 1ps
`default_nettype none

module dda_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dda_pkg::div_req_t req,
  output dda_pkg::div_rsp_t      rsp
);

  logic                            busy;
  logic                            done;
  logic [dda_pkg::DIV_CNT_BITS-1:0] cnt;
  dda_pkg::coord_t                 k_r;
  dda_pkg::coord_t                 rx;
  dda_pkg::coord_t                 ry;
  dda_pkg::quo_t                   qx;
  dda_pkg::quo_t                   qy;
  logic [dda_pkg::COORD_BITS:0]    tx;
  logic [dda_pkg::COORD_BITS:0]    ty;
  logic                            gex;
  logic                            gey;
  dda_pkg::coord_t                 rx_next;
  dda_pkg::coord_t                 ry_next;

  // Restoring division of (mag << FRAC_BITS) by k, one quotient bit per
  // cycle for both axes. The first step compares the bare magnitude, which
  // gives the integer bit of the quotient.
  always_comb begin
    tx      = (cnt == '0) ? {1'b0, rx} : {rx, 1'b0};
    ty      = (cnt == '0) ? {1'b0, ry} : {ry, 1'b0};
    gex     = tx >= {1'b0, k_r};
    gey     = ty >= {1'b0, k_r};
    rx_next = gex ? dda_pkg::COORD_BITS'(tx - {1'b0, k_r})
                  : dda_pkg::COORD_BITS'(tx);
    ry_next = gey ? dda_pkg::COORD_BITS'(ty - {1'b0, k_r})
                  : dda_pkg::COORD_BITS'(ty);
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rx  <= req.mag_x;
      ry  <= req.mag_y;
      k_r <= req.k;
    end else if (busy) begin
      rx <= rx_next;
      ry <= ry_next;
      qx <= {qx[dda_pkg::QUO_BITS-2:0], gex};
      qy <= {qy[dda_pkg::QUO_BITS-2:0], gey};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == dda_pkg::DIV_CNT_BITS'(dda_pkg::FRAC_BITS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.q_x  = qx;
  assign rsp.q_y  = qy;

endmodule

`default_nettype wire

FILE: src/dda_back.sv
`timescale 1ns / 1ps
`default_nettype none

module dda_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  input  wire dda_pkg::cmd_t     cmd,
  output logic                   cmd_take,
  output dda_pkg::div_req_t      div_req,
  input  wire dda_pkg::div_rsp_t div_rsp,
  output logic                   empty,
  input  wire logic              pop,
  output dda_pkg::res_t          res
);

  dda_pkg::state_t           state;
  dda_pkg::state_t           state_next;
  dda_pkg::pos_t             pos_x;
  dda_pkg::pos_t             pos_y;
  dda_pkg::inc_t             inc_x;
  dda_pkg::inc_t             inc_y;
  dda_pkg::coord_t           steps_left;
  logic                      line_active;
  logic                      neg_x;
  logic                      neg_y;

  dda_pkg::res_t             rq_mem [dda_pkg::RQ_DEPTH];
  logic [dda_pkg::RQ_AW-1:0] rq_wr;
  logic [dda_pkg::RQ_AW-1:0] rq_rd;
  logic [dda_pkg::RQ_AW:0]   rq_cnt;
  logic                      rq_full;
  logic                      rq_push;
  logic                      rq_pop;

  dda_pkg::pos_t             step_x;
  dda_pkg::pos_t             step_y;
  dda_pkg::coord_t           steps_dec;
  dda_pkg::res_t             res_in;
  dda_pkg::inc_t             qx_ext;
  dda_pkg::inc_t             qy_ext;
  logic                      is_start;
  logic                      long_line;

  assign is_start  = (cmd.action == dda_pkg::ACT_START);
  assign long_line = (cmd.k != '0);

  // Datapath for a step and for the result of the current command.
  always_comb begin
    step_x = pos_x + {{(dda_pkg::POS_BITS - dda_pkg::INC_BITS){inc_x[dda_pkg::INC_BITS-1]}},
                      inc_x};
    step_y = pos_y + {{(dda_pkg::POS_BITS - dda_pkg::INC_BITS){inc_y[dda_pkg::INC_BITS-1]}},
                      inc_y};
    steps_dec = steps_left - 1'b1;
    qx_ext    = {1'b0, div_rsp.q_x};
    qy_ext    = {1'b0, div_rsp.q_y};
    res_in    = '0;
    case (cmd.action)
      dda_pkg::ACT_START: begin
        res_in.px   = cmd.sx;
        res_in.py   = cmd.sy;
        res_in.last = !long_line;
      end
      dda_pkg::ACT_STEP: begin
        if (line_active) begin
          res_in.px   = dda_pkg::round_pixel(step_x);
          res_in.py   = dda_pkg::round_pixel(step_y);
          res_in.last = (steps_dec == '0);
        end else begin
          res_in.nal = 1'b1;
        end
      end
      default: res_in = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      dda_pkg::ST_RUN: begin
        if (cmd_take && is_start && long_line) begin
          state_next = dda_pkg::ST_DIV;
        end
      end
      dda_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_next = dda_pkg::ST_RUN;
        end
      end
      default: state_next = dda_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    cmd_take      = 1'b0;
    div_req.start = 1'b0;
    div_req.mag_x = cmd.mag_x;
    div_req.mag_y = cmd.mag_y;
    div_req.k     = cmd.k;
    case (state)
      dda_pkg::ST_RUN: begin
        cmd_take      = cmd_valid && !rq_full;
        div_req.start = cmd_valid && !rq_full && is_start && long_line;
      end
      dda_pkg::ST_DIV: begin
        cmd_take      = 1'b0;
        div_req.start = 1'b0;
      end
      default: begin
        cmd_take      = 1'b0;
        div_req.start = 1'b0;
      end
    endcase
  end

  assign rq_push = cmd_take;

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      if (is_start) begin
        pos_x <= {cmd.sx, {dda_pkg::FRAC_BITS{1'b0}}};
        pos_y <= {cmd.sy, {dda_pkg::FRAC_BITS{1'b0}}};
        neg_x <= cmd.neg_x;
        neg_y <= cmd.neg_y;
      end else if (line_active) begin
        pos_x <= step_x;
        pos_y <= step_y;
      end
    end
    if (state == dda_pkg::ST_DIV && div_rsp.done) begin
      inc_x <= neg_x ? (~qx_ext + 1'b1) : qx_ext;
      inc_y <= neg_y ? (~qy_ext + 1'b1) : qy_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dda_pkg::ST_RUN;
      steps_left  <= '0;
      line_active <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd_take) begin
        if (is_start) begin
          steps_left  <= cmd.k;
          line_active <= long_line;
        end else if (line_active) begin
          steps_left <= steps_dec;
          if (steps_dec == '0) begin
            line_active <= 1'b0;
          end
        end
      end
    end
  end

  // Result queue toward the output ports.
  assign rq_full = (rq_cnt == (dda_pkg::RQ_AW + 1)'(dda_pkg::RQ_DEPTH));
  assign empty   = (rq_cnt == '0);
  assign rq_pop  = pop && !empty;
  assign res     = rq_mem[rq_rd];

  always_ff @(posedge clk) begin
    if (rq_push) begin
      rq_mem[rq_wr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr  <= '0;
      rq_rd  <= '0;
      rq_cnt <= '0;
    end else begin
      if (rq_push) begin
        rq_wr <= rq_wr + 1'b1;
      end
      if (rq_pop) begin
        rq_rd <= rq_rd + 1'b1;
      end
      case ({rq_push, rq_pop})
        2'b10:   rq_cnt <= rq_cnt + 1'b1;
        2'b01:   rq_cnt <= rq_cnt - 1'b1;
        default: rq_cnt <= rq_cnt;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_active_has_steps: assert property (@(posedge clk) disable iff (rst)
    line_active |-> (steps_left != '0))
    else $error("line active with no steps left");

  a_div_enters_wait: assert property (@(posedge clk) disable iff (rst)
    div_req.start |=> (state == dda_pkg::ST_DIV))
    else $error("divider started without waiting for its quotient");

  a_done_only_waiting: assert property (@(posedge clk) disable iff (rst)
    (state == dda_pkg::ST_RUN) |-> !div_rsp.done)
    else $error("quotient arrived while no division was pending");

  a_rq_bound: assert property (@(posedge clk) disable iff (rst)
    rq_cnt <= (dda_pkg::RQ_AW + 1)'(dda_pkg::RQ_DEPTH))
    else $error("result queue overflow");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dda_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int TAIL_CYCLES  = 2 * (FRAC_BITS + 2) + 16;
  localparam int MAX_REPORTS  = 10;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   push = 1'b0;
  logic   full;
  logic   action = 1'b0;
  coord_t start_x = '0;
  coord_t start_y = '0;
  coord_t end_x = '0;
  coord_t end_y = '0;
  logic   empty;
  logic   pop = 1'b0;
  coord_t pixel_x;
  coord_t pixel_y;
  logic   last_pixel;
  logic   no_active_line;

  dda_line_rasterizer_top DUT (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .action         (action),
    .start_x        (start_x),
    .start_y        (start_y),
    .end_x          (end_x),
    .end_y          (end_y),
    .empty          (empty),
    .pop            (pop),
    .pixel_x        (pixel_x),
    .pixel_y        (pixel_y),
    .last_pixel     (last_pixel),
    .no_active_line (no_active_line)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Rasterizer state as the testbench tracks it.
  pos_t                pen_x;
  pos_t                pen_y;
  inc_t                slope_x;
  inc_t                slope_y;
  logic [COORD_BITS:0] steps_to_go;
  logic                drawing;

  res_t expected_pixels[$];
  res_t want;

  int send_idle_pct = 17;
  int recv_idle_pct = 60;
  int items_sent = 0;
  int lines_started = 0;
  int idle_steps = 0;
  int last_pixels = 0;
  int pixels_checked = 0;
  int mismatches = 0;
  int cycles = 0;

  function automatic coord_t nearest_pixel(input pos_t p);
    return p[FRAC_BITS +: COORD_BITS] + coord_t'(p[FRAC_BITS-1]);
  endfunction

  // Signed per-step increment, truncated toward zero.
  function automatic inc_t axis_increment(input coord_t from, input coord_t to,
                                          input coord_t k);
    pos_t scaled;
    pos_t q;
    scaled = pos_t'((to >= from) ? to - from : from - to) << FRAC_BITS;
    q = scaled / pos_t'(k);
    if (to < from) q = -q;
    return q[INC_BITS-1:0];
  endfunction

  function automatic int line_steps(input coord_t sx, input coord_t sy,
                                    input coord_t ex, input coord_t ey);
    int adx;
    int ady;
    adx = (ex >= sx) ? ex - sx : sx - ex;
    ady = (ey >= sy) ? ey - sy : sy - ey;
    return (adx > ady) ? adx : ady;
  endfunction

  function automatic coord_t near_coord(input coord_t c);
    int v;
    v = int'(c) + int'($urandom_range(16)) - 8;
    if (v < 0) v = 0;
    if (v > (1 << COORD_BITS) - 1) v = (1 << COORD_BITS) - 1;
    return coord_t'(v);
  endfunction

  task automatic predict_pixel(input action_t act, input coord_t sx, input coord_t sy,
                               input coord_t ex, input coord_t ey, output res_t px);
    coord_t k;
    px = '0;
    if (act == ACT_START) begin
      k = coord_t'(line_steps(sx, sy, ex, ey));
      pen_x = pos_t'(sx) << FRAC_BITS;
      pen_y = pos_t'(sy) << FRAC_BITS;
      lines_started++;
      if (k == 0) begin
        slope_x = '0;
        slope_y = '0;
        steps_to_go = '0;
        drawing = 1'b0;
      end else begin
        slope_x = axis_increment(sx, ex, k);
        slope_y = axis_increment(sy, ey, k);
        steps_to_go = k;
        drawing = 1'b1;
      end
      px.px = nearest_pixel(pen_x);
      px.py = nearest_pixel(pen_y);
      px.last = !drawing;
    end else if (!drawing) begin
      px.nal = 1'b1;
      idle_steps++;
    end else begin
      pen_x = pen_x + {{(POS_BITS-INC_BITS){slope_x[INC_BITS-1]}}, slope_x};
      pen_y = pen_y + {{(POS_BITS-INC_BITS){slope_y[INC_BITS-1]}}, slope_y};
      if (steps_to_go != 0) steps_to_go = steps_to_go - 1'b1;
      px.px = nearest_pixel(pen_x);
      px.py = nearest_pixel(pen_y);
      if (steps_to_go == 0) begin
        drawing = 1'b0;
        px.last = 1'b1;
      end
    end
    if (px.last) last_pixels++;
  endtask

  // Holds one item on the input until the transfer happens, then records
  // the pixel it must produce.
  task automatic send_item(input action_t act, input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey);
    res_t px;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    action <= act;
    start_x <= sx;
    start_y <= sy;
    end_x <= ex;
    end_y <= ey;
    do @(posedge clk); while (full);
    predict_pixel(act, sx, sy, ex, ey, px);
    expected_pixels.push_back(px);
    items_sent++;
  endtask

  task automatic send_step();
    send_item(ACT_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom));
  endtask

  task automatic draw_line(input coord_t sx, input coord_t sy, input coord_t ex,
                           input coord_t ey, input int n_steps);
    send_item(ACT_START, sx, sy, ex, ey);
    repeat (n_steps) send_step();
  endtask

  task automatic wait_for_drain();
    push <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
  endtask

  task automatic test_step_without_line();
    send_step();
  endtask

  task automatic test_zero_length();
    draw_line('0, '0, '0, '0, 0);
    draw_line('1, '1, '1, '1, 0);
    send_step();
  endtask

  // One short line per major axis and sign, then a step past the end.
  task automatic test_each_direction();
    draw_line(9'd10, 9'd20, 9'd12, 9'd21, 2);
    draw_line(9'd300, 9'd40, 9'd298, 9'd39, 2);
    draw_line(9'd100, 9'd100, 9'd101, 9'd102, 2);
    draw_line(9'd50, 9'd60, 9'd49, 9'd58, 2);
    send_step();
  endtask

  // Corners of the coordinate range, and a start that cuts a line short.
  task automatic test_extremes();
    draw_line(9'd510, 9'd510, 9'd511, 9'd511, 1);
    draw_line(9'd0, 9'd511, 9'd511, 9'd0, 1);
    draw_line(9'd511, 9'd0, 9'd0, 9'd511, 1);
  endtask

  // Mostly complete short lines; some long ones, some cut short, some
  // stepped past their end, and a few arbitrary items.
  task automatic test_random_lines(input int count);
    int     first;
    int     k;
    int     n;
    int     pick;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    first = items_sent;
    while (items_sent - first < count) begin
      sx = coord_t'($urandom);
      sy = coord_t'($urandom);
      if ($urandom_range(99) < 4) begin
        ex = coord_t'($urandom);
        ey = coord_t'($urandom);
      end else begin
        ex = near_coord(sx);
        ey = near_coord(sy);
      end
      k = line_steps(sx, sy, ex, ey);
      pick = $urandom_range(99);
      if (pick < 80) begin
        n = k;
      end else if (pick < 90) begin
        n = (k > 0) ? $urandom_range(k - 1) : 0;
      end else if (pick < 96) begin
        n = k + $urandom_range(3, 1);
      end else begin
        n = -1;
        send_item(action_t'($urandom_range(1)), sx, sy, ex, ey);
      end
      if (n >= 0) draw_line(sx, sy, ex, ey, n);
    end
  endtask

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR cycle %0d: unexpected pixel x=%0d y=%0d last=%0b nal=%0b",
                   cycles, pixel_x, pixel_y, last_pixel, no_active_line);
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (pixel_x !== want.px || pixel_y !== want.py || last_pixel !== want.last ||
            no_active_line !== want.nal) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"ERROR cycle %0d: expected x=%0d y=%0d last=%0b nal=%0b, ",
                      "got x=%0d y=%0d last=%0b nal=%0b"},
                     cycles, want.px, want.py, want.last, want.nal,
                     pixel_x, pixel_y, last_pixel, no_active_line);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d pixels outstanding", cycles,
               expected_pixels.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_step_without_line();
    test_zero_length();
    test_each_direction();
    test_extremes();
    test_random_lines(650);
    wait_for_drain();

    send_idle_pct = 60;
    recv_idle_pct = 17;
    test_random_lines(650);
    wait_for_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_lines(650);
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d items: %0d line starts, %0d steps with no line, %0d line ends.",
             items_sent, lines_started, idle_steps, last_pixels);
    $display("Checked %0d pixels over three sender/receiver stall mixes in %0d cycles.",
             pixels_checked, cycles);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
